// ----- rtl/core/pfr_pkg.sv -----
// shared types and constants for the page frame replacement unit
// used by pfr_ctrl, pfr_datapath and page_frame_replacement
package pfr_pkg;

  localparam int FRAMES_DEF     = 64;
  localparam int STAMP_BITS_DEF = 32;

  localparam int OP_W       = 2;
  localparam int FRAME_NUM_W = 6;
  localparam int FIU_W      = 7;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = 1;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_MODE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FIU  = 1'b1;

  localparam logic MODE_LRU   = 1'b0;
  localparam logic MODE_CLOCK = 1'b1;

  localparam logic [FIU_W-1:0] FIU_RESET = 7'd64;

  typedef struct packed {
    logic capture;
    logic ptr_clr;
    logic ptr_inc;
    logic take_ptr;
    logic lru_rd;
    logic lru_cmp;
    logic clk_init;
    logic clk_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic mode_clock;
    logic ptr_free;
    logic ptr_last;
    logic clk_hit;
    logic out_ready;
  } sts_t;

endpackage

// ----- rtl/core/pfr_ctrl.sv -----
// sequencer for the page frame replacement unit
// issues cmd_t to pfr_datapath and reacts to its sts_t; depends on pfr_pkg
module pfr_ctrl import pfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_FREE     = 3'd2;
  localparam logic [2:0] ST_LRU_RD   = 3'd3;
  localparam logic [2:0] ST_LRU_CMP  = 3'd4;
  localparam logic [2:0] ST_CLK_INIT = 3'd5;
  localparam logic [2:0] ST_CLK      = 3'd6;
  localparam logic [2:0] ST_FINISH   = 3'd7;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = sts_i.is_load ? ST_FREE : ST_FINISH;
      end
      ST_FREE: begin
        priority if (sts_i.ptr_free) begin
          cmd_o.take_ptr = 1'b1;
          state_d = ST_FINISH;
        end else if (sts_i.ptr_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d = sts_i.mode_clock ? ST_CLK_INIT : ST_LRU_RD;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      ST_LRU_RD: begin
        cmd_o.lru_rd = 1'b1;
        state_d = ST_LRU_CMP;
      end
      ST_LRU_CMP: begin
        cmd_o.lru_cmp = 1'b1;
        if (sts_i.ptr_last) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d = ST_LRU_RD;
        end
      end
      ST_CLK_INIT: begin
        cmd_o.clk_init = 1'b1;
        state_d = ST_CLK;
      end
      ST_CLK: begin
        cmd_o.clk_step = 1'b1;
        if (sts_i.clk_hit) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_ready) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/pfr_datapath.sv -----
// frame table, stamp memory, clock hand, access counter and result register
// driven by pfr_ctrl through cmd_t; depends on pfr_pkg
module pfr_datapath import pfr_pkg::*; #(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   mode_i,
  input  logic [FIU_W-1:0]       fiu_i,
  input  logic [OP_W-1:0]        op_i,
  input  logic [FRAME_NUM_W-1:0] frame_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [FRAME_NUM_W-1:0] frame_number_o,
  output logic                   replaced_o,
  output logic                   victim_dirty_o,
  output logic                   bad_index_o
);

  localparam int FW   = $clog2(FRAMES);
  localparam int NW   = $clog2(FRAMES + 1);
  localparam int CW   = (NW > FIU_W) ? NW : FIU_W;
  localparam int CW_I = (CW > FRAME_NUM_W) ? CW : FRAME_NUM_W;

  logic [FRAMES-1:0]     free_q, mod_q, rec_q, svld_q;
  logic [STAMP_BITS-1:0] stamp_mem [FRAMES];
  logic [STAMP_BITS-1:0] rd_q, best_q, cnt_q, cnt_d, stamp_rd;
  logic                  rd_vld_q;

  logic [OP_W-1:0]        op_q;
  logic [FRAME_NUM_W-1:0] idx_q;
  logic [CW-1:0]          n_q, n_d, fiu_w;
  logic                   mode_q;
  logic [FW-1:0]          ptr_q, sel_q, hand_q, hand_nx, idx_f, wr_addr;
  logic [1:0]             sweep_q;
  logic                   repl_q;
  logic                   bad, wr_en, ptr_last, hand_last, clk_hit;

  logic                   out_valid_q;
  logic [FRAME_NUM_W-1:0] num_q, num_d;
  logic                   repl_o_q, dirty_q, bad_q, dirty_d, bad_d;

  // clamp of the participating frame count
  always_comb begin
    fiu_w = CW'(fiu_i);
    priority if (fiu_w == '0) begin
      n_d = CW'(1);
    end else if (fiu_w > CW'(FRAMES)) begin
      n_d = CW'(FRAMES);
    end else begin
      n_d = fiu_w;
    end
  end

  assign idx_f     = FW'(idx_q);
  assign bad       = (CW_I'(idx_q) >= CW_I'(n_q));
  assign ptr_last  = (CW'(ptr_q) == n_q - CW'(1));
  assign hand_last = (CW'(hand_q) == n_q - CW'(1));
  assign hand_nx   = hand_last ? '0 : hand_q + FW'(1);
  assign clk_hit   = sweep_q[0] ? (!rec_q[hand_q] && mod_q[hand_q])
                                : (!mod_q[hand_q] && !rec_q[hand_q]);
  assign stamp_rd  = rd_vld_q ? rd_q : '0;
  assign cnt_d     = (cnt_q == '1) ? cnt_q : cnt_q + STAMP_BITS'(1);

  assign sts_o.is_load    = (op_q == OP_LOAD);
  assign sts_o.mode_clock = (mode_q == MODE_CLOCK);
  assign sts_o.ptr_free   = free_q[ptr_q];
  assign sts_o.ptr_last   = ptr_last;
  assign sts_o.clk_hit    = clk_hit;
  assign sts_o.out_ready  = !out_valid_q || !out_stall_i;

  // result and stamp write of the finishing word
  always_comb begin
    num_d   = idx_q;
    dirty_d = 1'b0;
    bad_d   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = idx_f;
    unique case (op_q)
      OP_LOAD: begin
        num_d   = FRAME_NUM_W'(sel_q);
        dirty_d = repl_q && mod_q[sel_q];
        wr_en   = 1'b1;
        wr_addr = sel_q;
      end
      OP_WRITE: begin
        bad_d = bad;
        wr_en = !bad;
      end
      OP_RELEASE: begin
        bad_d = bad;
      end
      default: begin
        num_d = idx_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '1;
      mod_q   <= '0;
      rec_q   <= '0;
      svld_q  <= '0;
      cnt_q   <= '0;
      hand_q  <= '0;
      sweep_q <= '0;
      ptr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture || cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + FW'(1);
      end
      if (cmd_i.clk_init) begin
        sweep_q <= '0;
        if (CW'(hand_q) >= n_q) begin
          hand_q <= '0;
        end
      end
      if (cmd_i.clk_step) begin
        hand_q <= hand_nx;
        if (!clk_hit) begin
          if (sweep_q[0]) begin
            rec_q[hand_q] <= 1'b0;
          end
          if (ptr_last) begin
            ptr_q   <= '0;
            sweep_q <= sweep_q + 2'd1;
          end else begin
            ptr_q <= ptr_q + FW'(1);
          end
        end
      end
      if (cmd_i.finish) begin
        if (wr_en) begin
          cnt_q <= cnt_d;
          svld_q[wr_addr] <= 1'b1;
          rec_q[wr_addr]  <= 1'b1;
          mod_q[wr_addr]  <= (op_q == OP_WRITE);
        end
        if (op_q == OP_LOAD) begin
          free_q[sel_q] <= 1'b0;
        end
        if (op_q == OP_RELEASE && !bad) begin
          free_q[idx_f] <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      idx_q  <= frame_index_i;
      n_q    <= n_d;
      mode_q <= mode_i;
      repl_q <= 1'b0;
    end
    if (cmd_i.take_ptr) begin
      sel_q  <= ptr_q;
      repl_q <= 1'b0;
    end
    if (cmd_i.lru_cmp) begin
      repl_q <= 1'b1;
      if (ptr_q == '0 || !(best_q < stamp_rd)) begin
        best_q <= stamp_rd;
        sel_q  <= ptr_q;
      end
    end
    if (cmd_i.clk_step && clk_hit) begin
      sel_q  <= hand_q;
      repl_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      num_q    <= num_d;
      repl_o_q <= (op_q == OP_LOAD) && repl_q;
      dirty_q  <= dirty_d;
      bad_q    <= bad_d;
    end
  end

  // stamp memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && wr_en) begin
      stamp_mem[wr_addr] <= cnt_d;
    end
    if (cmd_i.lru_rd) begin
      rd_q     <= stamp_mem[ptr_q];
      rd_vld_q <= svld_q[ptr_q];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_number_o = num_q;
  assign replaced_o     = repl_o_q;
  assign victim_dirty_o = dirty_q;
  assign bad_index_o    = bad_q;

endmodule

// ----- rtl/core/page_frame_replacement.sv -----
// top level of the page frame replacement unit: config registers and the
// pfr_ctrl / pfr_datapath pair; depends on pfr_pkg
//
// a word on the input channel carries op_i (load, write access, release) and
// frame_index_i; each accepted word gives exactly one result word on the
// output channel. both channels use valid and stall, a word moves at a clock
// edge with valid high and stall low.
// one word is worked on at a time; with n frames in use:
//   write access, release, bad index: a dispatch step, then the finish step
//   load with a free frame at index k: free bits scanned one a cycle up to k
//   load in lru mode: free scan, then the stamp memory is read frame by frame,
//   each frame a read step, then a compare step
//   load in clock mode: free scan, then the hand walks one frame a cycle; a
//   victim turns up by the first frame of the fourth sweep
// a new word is taken while the last result still waits; if out_stall_i holds
// that result, the next one waits in the finish step and input stalls.
// reset frees every frame, clears use, modified and stamps, the hand and the
// access counter, and selects lru over 64 frames. the user is to write configuration
// over the apb-style port only while the unit is idle; the block does not enforce it.
module page_frame_replacement import pfr_pkg::*; #(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [DATA_W-1:0]      pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OP_W-1:0]        op_i,
  input  logic [FRAME_NUM_W-1:0] frame_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [FRAME_NUM_W-1:0] frame_number_o,
  output logic                   replaced_o,
  output logic                   victim_dirty_o,
  output logic                   bad_index_o
);

  logic             mode_q;
  logic [FIU_W-1:0] fiu_q;
  logic [REG_IDX_W-1:0] reg_idx;
  cmd_t cmd;
  sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LRU;
      fiu_q  <= FIU_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MODE: mode_q <= pwdata[0];
        REG_FIU:  fiu_q  <= pwdata[FIU_W-1:0];
        default:  mode_q <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE: prdata = DATA_W'(mode_q);
      REG_FIU:  prdata = DATA_W'(fiu_q);
      default:  prdata = '0;
    endcase
  end

  pfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfr_datapath #(
    .FRAMES     (FRAMES),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (mode_q),
    .fiu_i          (fiu_q),
    .op_i           (op_i),
    .frame_index_i  (frame_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_number_o (frame_number_o),
    .replaced_o     (replaced_o),
    .victim_dirty_o (victim_dirty_o),
    .bad_index_o    (bad_index_o)
  );

endmodule
